FILE: hw/rtl/mmpr_pkg.sv
// Shared types, constants and helpers of the modular matrix power recurrence block.
`default_nettype none
package mmpr_pkg;

	localparam int unsigned WORD_W = 30;
	localparam logic [WORD_W-1:0] MODULUS = 30'd1000000007;
	// Barrett factor floor(2^60 / P), fits in 31 bits.
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

	localparam int unsigned NUM_REGS = 7;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned TAG_W = 3;
	localparam int unsigned MM_LAT = 6;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [TAG_W-1:0] tag_t;

	localparam reg_idx_t REG_BASE_M00 = 3'd0;
	localparam reg_idx_t REG_BASE_M01 = 3'd1;
	localparam reg_idx_t REG_BASE_M10 = 3'd2;
	localparam reg_idx_t REG_BASE_M11 = 3'd3;
	localparam reg_idx_t REG_START_C0 = 3'd4;
	localparam reg_idx_t REG_START_C1 = 3'd5;
	localparam reg_idx_t REG_ANSWER_TWO = 3'd6;

	localparam word_t RST_BASE_M00 = 30'd2;
	localparam word_t RST_BASE_M01 = 30'd1;
	localparam word_t RST_BASE_M10 = 30'd3;
	localparam word_t RST_BASE_M11 = 30'd0;
	localparam word_t RST_START_C0 = 30'd24;
	localparam word_t RST_START_C1 = 30'd12;
	localparam word_t RST_ANSWER_TWO = 30'd12;

	typedef struct packed {
		logic vld;
		tag_t tag;
	} mm_req_t;

	typedef struct packed {
		logic  vld;
		tag_t  tag;
		word_t value;
	} mm_rsp_t;

	// Any 30-bit value is below 2P, so one conditional subtract reduces it.
	function automatic word_t reduce_word(input word_t v);
		reduce_word = (v >= MODULUS) ? v - MODULUS : v;
	endfunction

	function automatic word_t add_mod(input word_t a, input word_t b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODULUS}) begin
			s = s - {1'b0, MODULUS};
		end
		add_mod = s[WORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mmpr_mulmod.sv
// Pipelined modular multiplier: product of two reduced words modulo P by Barrett reduction.
`default_nettype none
module mmpr_mulmod (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  mmpr_pkg::mm_req_t     req,
	input  mmpr_pkg::word_t       a,
	input  mmpr_pkg::word_t       b,
	output mmpr_pkg::mm_rsp_t     rsp
);

	logic [mmpr_pkg::MM_LAT-1:0] vld_q;
	mmpr_pkg::tag_t              tag_q [mmpr_pkg::MM_LAT];

	logic [59:0] x_s1;
	logic [61:0] q_s2;
	logic [31:0] xl_s2;
	logic [31:0] qp_s3;
	logic [31:0] xl_s3;
	logic [31:0] r_s4;
	logic [31:0] r_s5;
	mmpr_pkg::word_t r_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[mmpr_pkg::MM_LAT-2:0], req.vld};
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= req.tag;
		for (int i = 1; i < mmpr_pkg::MM_LAT; i++) begin
			tag_q[i] <= tag_q[i-1];
		end
		x_s1  <= 60'(a) * 60'(b);
		q_s2  <= 62'(x_s1[59:29]) * 62'(mmpr_pkg::BARRETT_MU);
		xl_s2 <= x_s1[31:0];
		// Only the low 32 bits matter: the true remainder is below 3P.
		qp_s3 <= 32'(q_s2[61:31]) * 32'(mmpr_pkg::MODULUS);
		xl_s3 <= xl_s2;
		r_s4  <= xl_s3 - qp_s3;
		r_s5  <= (r_s4 >= 32'(mmpr_pkg::MODULUS)) ? r_s4 - 32'(mmpr_pkg::MODULUS) : r_s4;
		r_s6  <= (r_s5 >= 32'(mmpr_pkg::MODULUS)) ?
			30'(r_s5 - 32'(mmpr_pkg::MODULUS)) : r_s5[29:0];
	end

	assign rsp.vld   = vld_q[mmpr_pkg::MM_LAT-1];
	assign rsp.tag   = tag_q[mmpr_pkg::MM_LAT-1];
	assign rsp.value = r_s6;

endmodule
`default_nettype wire

FILE: hw/rtl/mod_matrix_power_recurrence.sv
// Top level: configuration registers, square-and-multiply sequencer and output register.
//
// Each query takes one beat in and gives one beat out. Index two or below gives the reduced
// answer-two register as its result. Otherwise the exponent n-3 is walked one bit at a time.
// Each 2x2 matrix product issues eight modular multiplies into the shared six-stage Barrett
// multiplier and then sums pairs. An exponent bit costs a square only (bit clear) or a
// multiply and square (bit set); two more multiplies with the start coefficients end the
// query. The input stalls while a query is in progress.
// Configuration must be written only while the block is idle: the start coefficients are
// read again at the end of a query.
`default_nettype none
module mod_matrix_power_recurrence #(
	parameter int unsigned EXP_WIDTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [63:0]                query_index,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [29:0]                     term_value,
	input  wire logic                       cfg_we,
	input  wire logic [2:0]                 cfg_index,
	input  wire logic [29:0]                cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_RUN,
		S_SUM,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_SQR,
		OP_FIN
	} op_t;

	state_t state_q;
	op_t    op_q;

	mmpr_pkg::word_t cfg_q [mmpr_pkg::NUM_REGS];
	mmpr_pkg::word_t acc_q [4];
	mmpr_pkg::word_t base_q [4];
	mmpr_pkg::word_t prod_q [8];
	mmpr_pkg::word_t res_q;
	mmpr_pkg::word_t term_value_q;
	logic            out_valid_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [3:0]      iss_q;
	logic [3:0]      rcnt_q;

	logic [3:0]      total;
	logic            in_acc;
	logic            out_acc;
	logic [63:0]     n_minus3;
	mmpr_pkg::mm_req_t req;
	mmpr_pkg::mm_rsp_t rsp;
	mmpr_pkg::word_t opa;
	mmpr_pkg::word_t opb;
	mmpr_pkg::word_t sum [4];

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_acc    = out_valid_q && !out_stall;
	assign out_valid  = out_valid_q;
	assign term_value = term_value_q;
	assign total      = (op_q == OP_FIN) ? 4'd2 : 4'd8;
	assign n_minus3   = query_index - 64'd3;

	assign req.vld = (state_q == S_RUN) && (iss_q < total);
	assign req.tag = iss_q[2:0];

	always_comb begin
		case (op_q)
			OP_ACC: begin
				opa = acc_q[{iss_q[2], iss_q[0]}];
				opb = base_q[{iss_q[0], iss_q[1]}];
			end
			OP_SQR: begin
				opa = base_q[{iss_q[2], iss_q[0]}];
				opb = base_q[{iss_q[0], iss_q[1]}];
			end
			OP_FIN: begin
				opa = iss_q[0] ? mmpr_pkg::reduce_word(cfg_q[mmpr_pkg::REG_START_C1]) :
					mmpr_pkg::reduce_word(cfg_q[mmpr_pkg::REG_START_C0]);
				opb = acc_q[{iss_q[0], 1'b0}];
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sum[j] = mmpr_pkg::add_mod(prod_q[2*j], prod_q[2*j+1]);
		end
	end

	mmpr_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (opa),
		.b      (opb),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[mmpr_pkg::REG_BASE_M00]   <= mmpr_pkg::RST_BASE_M00;
			cfg_q[mmpr_pkg::REG_BASE_M01]   <= mmpr_pkg::RST_BASE_M01;
			cfg_q[mmpr_pkg::REG_BASE_M10]   <= mmpr_pkg::RST_BASE_M10;
			cfg_q[mmpr_pkg::REG_BASE_M11]   <= mmpr_pkg::RST_BASE_M11;
			cfg_q[mmpr_pkg::REG_START_C0]   <= mmpr_pkg::RST_START_C0;
			cfg_q[mmpr_pkg::REG_START_C1]   <= mmpr_pkg::RST_START_C1;
			cfg_q[mmpr_pkg::REG_ANSWER_TWO] <= mmpr_pkg::RST_ANSWER_TWO;
		end else if (cfg_we && (cfg_index <= mmpr_pkg::REG_ANSWER_TWO)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.vld) begin
			prod_q[rsp.tag] <= rsp.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_FIN;
			out_valid_q  <= 1'b0;
			iss_q        <= '0;
			rcnt_q       <= '0;
			exp_q        <= '0;
			res_q        <= '0;
			term_value_q <= '0;
			for (int i = 0; i < 4; i++) begin
				acc_q[i]  <= '0;
				base_q[i] <= '0;
			end
		end else begin
			if (out_acc && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (query_index <= 64'd2) begin
							res_q   <= mmpr_pkg::reduce_word(cfg_q[mmpr_pkg::REG_ANSWER_TWO]);
							state_q <= S_OUT;
						end else begin
							exp_q <= n_minus3[EXP_WIDTH-1:0];
							for (int i = 0; i < 4; i++) begin
								base_q[i] <= mmpr_pkg::reduce_word(cfg_q[i]);
							end
							acc_q[0] <= 30'd1;
							acc_q[1] <= 30'd0;
							acc_q[2] <= 30'd0;
							acc_q[3] <= 30'd1;
							state_q  <= S_STEP;
						end
					end
				end
				S_STEP: begin
					if (exp_q == '0) begin
						op_q <= OP_FIN;
					end else if (exp_q[0]) begin
						op_q <= OP_ACC;
					end else begin
						op_q <= OP_SQR;
					end
					iss_q   <= '0;
					rcnt_q  <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (req.vld) begin
						iss_q <= iss_q + 4'd1;
					end
					if (rsp.vld) begin
						rcnt_q <= rcnt_q + 4'd1;
						if (rcnt_q + 4'd1 == total) begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					case (op_q)
						OP_ACC: begin
							for (int i = 0; i < 4; i++) begin
								acc_q[i] <= sum[i];
							end
							op_q    <= OP_SQR;
							iss_q   <= '0;
							rcnt_q  <= '0;
							state_q <= S_RUN;
						end
						OP_SQR: begin
							for (int i = 0; i < 4; i++) begin
								base_q[i] <= sum[i];
							end
							exp_q   <= exp_q >> 1;
							state_q <= S_STEP;
						end
						OP_FIN: begin
							res_q   <= sum[0];
							state_q <= S_OUT;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_OUT: begin
					// The previous result must be gone before this one overwrites it.
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						term_value_q <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rsp_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.vld |-> (state_q == S_RUN))
		else $error("multiplier result outside a matrix product");

	a_issue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (iss_q <= total) && (rcnt_q <= iss_q))
		else $error("issue or return count out of range");

	a_sum_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (rcnt_q == total) && (iss_q == total))
		else $error("pair sums taken before all products returned");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (term_value_q < mmpr_pkg::MODULUS))
		else $error("result not reduced");

endmodule
`default_nettype wire
